// File: rtl/bpc_pkg.sv
// bpc_pkg: shared types and constants of the balance pid controller
// controller states, datapath command and status structs, register indexes
// depends on nothing
package bpc_pkg;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_PROP_GAIN    = 3'd0,
        REG_INTEG_GAIN   = 3'd1,
        REG_RATE_GAIN    = 3'd2,
        REG_DRIVE_LIMIT  = 3'd3,
        REG_INTEG_LIMIT  = 3'd4,
        REG_DEAD_ZONE    = 3'd5,
        REG_FLOOR_DRIVE  = 3'd6,
        REG_SLEW_PER_SEC = 3'd7
    } t_reg_idx;

    // sequencer states; each S_MUL_ state uses the multiplier once
    typedef enum logic [3:0] {
        S_IDLE,
        S_ZERO,
        S_TILT,
        S_MUL_DT,
        S_MUL_SHAPE,
        S_MUL_RATE,
        S_MUL_PROP,
        S_MUL_INTEG,
        S_MUL_SLEW,
        S_TARGET,
        S_UPDATE
    } t_state;

    typedef struct packed {
        logic   load;       // capture the input request
        t_state phase;      // current step of the sequence
        logic   out_load;   // write the output register
    } t_dp_cmd;

    typedef struct packed {
        logic dt_zero;      // offered request has a zero time step
    } t_dp_stat;

    // error shaping constants
    localparam int unsigned KNEE_Q8        = 512;
    localparam int unsigned SLOPE_Q16      = 7864;
    localparam int unsigned BOOST_CAP_Q16  = 42598;
    localparam int unsigned ONE_Q16        = 65536;
    // smallest |tilt| - knee whose boost reaches the cap
    localparam int unsigned BOOST_SAT_DIFF = 1387;

endpackage

// File: rtl/bpc_ctrl.sv
// bpc_ctrl: sequencer of the balance pid controller
// steps the datapath through one request and owns the output valid flag
// depends on bpc_pkg
module bpc_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    input  bpc_pkg::t_dp_stat  i_stat,
    output bpc_pkg::t_dp_cmd   o_cmd
);
    import bpc_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || i_out_ready;

    // state and output flag registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // next state and commands
    always_comb begin
        n_state        = r_state;
        o_cmd.load     = 1'b0;
        o_cmd.phase    = r_state;
        o_cmd.out_load = 1'b0;
        o_in_ready     = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_stat.dt_zero ? S_ZERO : S_TILT;
                end
            end
            S_ZERO: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_TILT:      n_state = S_MUL_DT;
            S_MUL_DT:    n_state = S_MUL_SHAPE;
            S_MUL_SHAPE: n_state = S_MUL_RATE;
            S_MUL_RATE:  n_state = S_MUL_PROP;
            S_MUL_PROP:  n_state = S_MUL_INTEG;
            S_MUL_INTEG: n_state = S_MUL_SLEW;
            S_MUL_SLEW:  n_state = S_TARGET;
            S_TARGET:    n_state = S_UPDATE;
            S_UPDATE: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default:     n_state = S_IDLE;
        endcase
        n_out_valid = o_cmd.out_load ? 1'b1 : (i_out_ready ? 1'b0 : r_out_valid);
    end

    assign o_out_valid = r_out_valid;

endmodule

// File: rtl/bpc_datapath.sv
// bpc_datapath: registers, shared multiplier and arithmetic of the controller
// holds configuration, integral and last drive state
// depends on bpc_pkg
module bpc_datapath #(
    parameter int AW = 16,
    parameter int DW = 24
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  bpc_pkg::t_dp_cmd     i_cmd,
    output bpc_pkg::t_dp_stat    o_stat,
    input  logic                 i_cfg_we,
    input  logic [2:0]           i_cfg_index,
    input  logic [31:0]          i_cfg_data,
    input  logic signed [AW-1:0] i_target_angle,
    input  logic signed [AW-1:0] i_measured_angle,
    input  logic signed [AW-1:0] i_angle_rate,
    input  logic [15:0]          i_step_time,
    output logic signed [DW-1:0] o_drive
);
    import bpc_pkg::*;

    localparam int XW = (AW + 2 > 17) ? AW + 2 : 17;
    localparam int MA = (AW + 2 > 33) ? AW + 2 : 33;
    localparam int MB = 33;
    localparam int MP = MA + MB;
    localparam int IW = ((AW + 18 > 40) ? AW + 18 : 40) + 1;
    localparam int KW = ((DW > 25) ? DW : 25) + 2;
    localparam logic signed [MP-1:0] SAT_T8 = MP'(64'h0010_0000_0000_0000);
    localparam logic signed [MP-1:0] SAT_T0 = MP'(64'h1000_0000_0000_0000);
    localparam logic signed [62:0]   SUM_CAP = 63'sh1000_0000_0000_0000;
    localparam logic [31:0] DRIVE_MAX = 32'((64'd1 << (DW - 1)) - 64'd1);

    // configuration registers
    logic signed [31:0] r_prop_gain, r_integ_gain, r_rate_gain;
    logic [22:0]        r_drive_limit, r_integ_limit, r_floor_drive, r_slew_per_sec;
    logic [14:0]        r_dead_zone;

    // request and working registers
    logic signed [AW-1:0] r_tgt, r_meas, r_rate;
    logic [15:0]          r_dt;
    logic signed [AW:0]   r_tilt;
    logic [AW:0]          r_tmag;
    logic [16:0]          r_factor;
    logic signed [MP-1:0] r_prod;
    logic signed [39:0]   r_integ;
    logic signed [AW+1:0] r_shaped;
    logic signed [32:0]   r_iq16;
    logic signed [62:0]   r_sum;
    logic signed [24:0]   r_target;
    logic [23:0]          r_dl;
    logic signed [DW-1:0] r_last, r_drive;

    logic cfg_clear;

    // saturate a product shifted left by 8 or 0 to plus or minus 2^60
    function automatic logic signed [62:0] sat_p(input logic signed [MP-1:0] p,
                                                 input logic sh8);
        logic signed [MP-1:0] thr;
        thr = sh8 ? SAT_T8 : SAT_T0;
        if (p > thr)
            return SUM_CAP;
        else if (p < -thr)
            return -SUM_CAP;
        else
            return sh8 ? 63'(p <<< 8) : 63'(p);
    endfunction

    assign o_stat.dt_zero = (i_step_time == 16'd0);
    assign cfg_clear = i_cfg_we && (i_cfg_index inside {REG_PROP_GAIN, REG_INTEG_GAIN,
                       REG_RATE_GAIN, REG_DRIVE_LIMIT, REG_INTEG_LIMIT});

    // deadband on the tilt error
    logic signed [XW-1:0] err, dz, tilt_w;
    logic signed [AW:0]   tilt_c;
    always_comb begin
        err = XW'(r_meas) - XW'(r_tgt);
        dz  = signed'(XW'(r_dead_zone));
        if (err > dz)
            tilt_w = err - dz;
        else if (err < -dz)
            tilt_w = err + dz;
        else
            tilt_w = '0;
        tilt_c = (AW+1)'(tilt_w);
    end

    // boost factor for errors past the knee
    logic [AW:0]   knee_x;
    logic [23:0]   boost_p;
    logic [16:0]   factor_c;
    always_comb begin
        knee_x  = r_tmag - (AW+1)'(KNEE_Q8);
        boost_p = 24'(knee_x[10:0]) * 24'(SLOPE_Q16);
        if (r_tmag <= (AW+1)'(KNEE_Q8))
            factor_c = 17'(ONE_Q16);
        else if (knee_x >= (AW+1)'(BOOST_SAT_DIFF))
            factor_c = 17'(ONE_Q16 + BOOST_CAP_Q16);
        else
            factor_c = 17'(ONE_Q16) + 17'(boost_p[23:8]);
    end

    // shared multiplier operand selection
    logic signed [MA-1:0] mul_a;
    logic signed [MB-1:0] mul_b;
    logic                 mul_en;
    always_comb begin
        mul_a  = '0;
        mul_b  = '0;
        mul_en = 1'b1;
        case (i_cmd.phase)
            S_MUL_DT: begin
                mul_a = MA'(r_tilt);
                mul_b = signed'(MB'(r_dt));
            end
            S_MUL_SHAPE: begin
                mul_a = signed'(MA'(r_tmag));
                mul_b = signed'(MB'(r_factor));
            end
            S_MUL_RATE: begin
                mul_a = MA'(r_rate);
                mul_b = MB'(r_rate_gain);
            end
            S_MUL_PROP: begin
                mul_a = MA'(r_shaped);
                mul_b = MB'(r_prop_gain);
            end
            S_MUL_INTEG: begin
                mul_a = MA'(r_iq16);
                mul_b = MB'(r_integ_gain);
            end
            S_MUL_SLEW: begin
                mul_a = signed'(MA'(r_slew_per_sec));
                mul_b = signed'(MB'(r_dt));
            end
            default: mul_en = 1'b0;
        endcase
    end

    // integral update, shaping and rounding of earlier products
    logic signed [IW-1:0] acc_sum, ilim, acc_c;
    logic signed [40:0]   iq_t;
    logic [MP-1:0]        prod_rnd;
    logic signed [AW+1:0] smag_s, shaped_c;
    always_comb begin
        acc_sum = IW'(r_integ) + IW'(r_prod);
        ilim    = signed'(IW'({r_integ_limit, 16'b0}));
        if (acc_sum > ilim)
            acc_c = ilim;
        else if (acc_sum < -ilim)
            acc_c = -ilim;
        else
            acc_c = acc_sum;
        iq_t     = 41'(r_integ) + 41'sd128;
        prod_rnd = r_prod + MP'(32768);
        smag_s   = signed'({1'b0, prod_rnd[16 +: AW+1]});
        shaped_c = r_tilt[AW] ? -smag_s : smag_s;
    end

    // target drive: round, clamp to the limit, apply the floor
    logic signed [63:0] tr;
    logic signed [39:0] tq, lim_s, fl_s, tgt_c;
    logic [22:0]        lim, fl;
    always_comb begin
        tr    = 64'(r_sum) + 64'sd8388608;
        tq    = tr[63:24];
        lim   = (32'(r_drive_limit) > DRIVE_MAX) ? 23'(DRIVE_MAX) : r_drive_limit;
        fl    = (r_floor_drive > lim) ? lim : r_floor_drive;
        lim_s = signed'(40'(lim));
        fl_s  = signed'(40'(fl));
        if (tq > lim_s)
            tgt_c = lim_s;
        else if (tq < -lim_s)
            tgt_c = -lim_s;
        else
            tgt_c = tq;
        if (r_tilt != '0 && tgt_c != '0) begin
            if (tgt_c > 0 && tgt_c < fl_s)
                tgt_c = fl_s;
            else if (tgt_c < 0 && tgt_c > -fl_s)
                tgt_c = -fl_s;
        end
    end

    // slew limited drive update
    logic signed [KW-1:0] last_k, tgt_k, dl_k, lim_k, diff, slew_step, nxt;
    always_comb begin
        last_k = KW'(r_last);
        tgt_k  = KW'(r_target);
        dl_k   = signed'(KW'(r_dl));
        lim_k  = signed'(KW'(lim));
        diff   = tgt_k - last_k;
        if (diff > dl_k)
            slew_step = dl_k;
        else if (diff < -dl_k)
            slew_step = -dl_k;
        else
            slew_step = diff;
        nxt = (r_slew_per_sec != '0) ? last_k + slew_step : tgt_k;
        if (nxt > lim_k)
            nxt = lim_k;
        else if (nxt < -lim_k)
            nxt = -lim_k;
    end

    // configuration and state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prop_gain    <= '0;
            r_integ_gain   <= '0;
            r_rate_gain    <= '0;
            r_drive_limit  <= '0;
            r_integ_limit  <= '0;
            r_dead_zone    <= '0;
            r_floor_drive  <= '0;
            r_slew_per_sec <= '0;
            r_integ        <= '0;
            r_last         <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_PROP_GAIN:    r_prop_gain    <= i_cfg_data;
                    REG_INTEG_GAIN:   r_integ_gain   <= i_cfg_data;
                    REG_RATE_GAIN:    r_rate_gain    <= i_cfg_data;
                    REG_DRIVE_LIMIT:  r_drive_limit  <= i_cfg_data[22:0];
                    REG_INTEG_LIMIT:  r_integ_limit  <= i_cfg_data[22:0];
                    REG_DEAD_ZONE:    r_dead_zone    <= i_cfg_data[14:0];
                    REG_FLOOR_DRIVE:  r_floor_drive  <= i_cfg_data[22:0];
                    REG_SLEW_PER_SEC: r_slew_per_sec <= i_cfg_data[22:0];
                    default: ;
                endcase
            end
            if (cfg_clear) begin
                r_integ <= '0;
                r_last  <= '0;
            end else begin
                if (i_cmd.phase == S_MUL_SHAPE)
                    r_integ <= 40'(acc_c);
                if (i_cmd.out_load && i_cmd.phase == S_UPDATE)
                    r_last <= DW'(nxt);
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_tgt  <= i_target_angle;
            r_meas <= i_measured_angle;
            r_rate <= i_angle_rate;
            r_dt   <= i_step_time;
        end
        if (mul_en)
            r_prod <= mul_a * mul_b;
        case (i_cmd.phase)
            S_TILT: begin
                r_tilt <= tilt_c;
                r_tmag <= tilt_c[AW] ? (AW+1)'(-tilt_c) : (AW+1)'(tilt_c);
            end
            S_MUL_DT:    r_factor <= factor_c;
            S_MUL_RATE: begin
                r_shaped <= shaped_c;
                r_iq16   <= iq_t[40:8];
            end
            S_MUL_PROP:  r_sum <= sat_p(r_prod, 1'b1);
            S_MUL_INTEG: r_sum <= r_sum + sat_p(r_prod, 1'b1);
            S_MUL_SLEW:  r_sum <= r_sum + sat_p(r_prod, 1'b0);
            S_TARGET: begin
                r_target <= 25'(tgt_c);
                r_dl     <= prod_rnd[16 +: 24];
            end
            default: ;
        endcase
        if (i_cmd.out_load)
            r_drive <= (i_cmd.phase == S_ZERO) ? '0 : DW'(nxt);
    end

    assign o_drive = r_drive;

endmodule

// File: rtl/balance_pid_controller.sv
// balance_pid_controller: top level of the balance pid controller
// joins the sequencer and the datapath; depends on bpc_pkg, bpc_ctrl, bpc_datapath
//
//   channel   direction  handshake                 payload
//   in        request    i_in_valid / o_in_ready   target, measured, rate, step time
//   out       result     o_out_valid / i_out_ready drive
//   cfg       write      i_cfg_we                  i_cfg_index, i_cfg_data
//
// a request with a nonzero step passes the tilt step, six passes through the one shared
// multiplier, and the target and update steps before it reaches the output register;
// a zero step reaches it from the zero state, right after acceptance
// the update and zero steps wait until the output register is free
// a new request is taken once the previous one reaches the output register
// reset clears configuration, integral and last drive; no clearing pass
// a stalled output holds the finished drive while the next request is taken
module balance_pid_controller #(
    parameter int ANGLE_WIDTH = 16,
    parameter int DRIVE_WIDTH = 24
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic signed [ANGLE_WIDTH-1:0] i_target_angle,
    input  logic signed [ANGLE_WIDTH-1:0] i_measured_angle,
    input  logic signed [ANGLE_WIDTH-1:0] i_angle_rate,
    input  logic [15:0]                   i_step_time,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic signed [DRIVE_WIDTH-1:0] o_drive,
    input  logic                          i_cfg_we,
    input  logic [2:0]                    i_cfg_index,
    input  logic [31:0]                   i_cfg_data
);
    import bpc_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    bpc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    bpc_datapath #(
        .AW (ANGLE_WIDTH),
        .DW (DRIVE_WIDTH)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_target_angle   (i_target_angle),
        .i_measured_angle (i_measured_angle),
        .i_angle_rate     (i_angle_rate),
        .i_step_time      (i_step_time),
        .o_drive          (o_drive)
    );

    // one request at a time: busy right after acceptance
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("request accepted while sequencer still busy");

    // the drive is clamped symmetrically, so the most negative code never shows
    a_drive_symmetric: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_drive != {1'b1, {(DRIVE_WIDTH-1){1'b0}}})
        else $error("drive outside symmetric limit");

    // the output register is only written when its slot is free
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> (!o_out_valid || i_out_ready))
        else $error("result overwritten before it was taken");

endmodule
